// ===== design/rtc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared sizes, codes and handshake types of the revocation tree cover block.
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int LEAVES      = 16;
  localparam int NODES       = 2 * LEAVES;
  localparam int LEAF_W      = $clog2(LEAVES);
  localparam int NODE_W      = $clog2(NODES);
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int KEY_W       = 64;
  localparam int TIME_W      = 32;
  localparam int MODE_W      = 2;
  localparam int KIND_W      = 2;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REVOKE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COVER    = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_REGISTERED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COVER      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_REVOKE,
    ST_COVER,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic advance;
    logic write_leaf;
    logic emit_full;
    logic mark_path;
    logic cover_take;
    logic cover_flush;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic leaf_free;
    logic leaf_hit;
    logic node_qual;
    logic leaf_end;
    logic node_end;
  } sts_t;

endpackage

// ===== design/rtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtc_ctrl
// Sequencer: dispatches on the mode and steps the datapath through the scan.
// ----------------------------------------------------------------------------
module rtc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rtc_pkg::MODE_W-1:0] in_mode,
  input  rtc_pkg::sts_t              sts,
  output rtc_pkg::cmd_t              cmd,
  output logic                       busy
);

  rtc_pkg::state_t state_r;
  rtc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != rtc_pkg::ST_IDLE);
    case (state_r)
      rtc_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (in_mode)
            rtc_pkg::MODE_REGISTER: state_nxt = rtc_pkg::ST_REG;
            rtc_pkg::MODE_REVOKE:   state_nxt = rtc_pkg::ST_REVOKE;
            rtc_pkg::MODE_COVER:    state_nxt = rtc_pkg::ST_COVER;
            default:                state_nxt = rtc_pkg::ST_IDLE;
          endcase
        end
      end
      rtc_pkg::ST_REG: begin
        if (sts.leaf_free) begin
          cmd.write_leaf = 1'b1;
          state_nxt      = rtc_pkg::ST_IDLE;
        end else if (sts.leaf_end) begin
          cmd.emit_full = 1'b1;
          state_nxt     = rtc_pkg::ST_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      rtc_pkg::ST_REVOKE: begin
        cmd.mark_path = sts.leaf_hit;
        if (sts.leaf_end) begin
          state_nxt = rtc_pkg::ST_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      rtc_pkg::ST_COVER: begin
        cmd.cover_take = sts.node_qual;
        if (sts.node_end) begin
          state_nxt = rtc_pkg::ST_FLUSH;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      rtc_pkg::ST_FLUSH: begin
        cmd.cover_flush = 1'b1;
        state_nxt       = rtc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rtc_pkg::ST_IDLE;
      end
    endcase
  end

  // Scan steps only happen inside a transfer in progress
  a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !(cmd.advance || cmd.write_leaf || cmd.mark_path || cmd.cover_take))
    else $error("scan command issued while idle");

  // A transfer is accepted only from idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == rtc_pkg::ST_IDLE))
    else $error("load outside idle");

  // Flush follows the final cover step
  a_flush_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtc_pkg::ST_COVER) && sts.node_end |=> cmd.cover_flush)
    else $error("cover scan did not end in flush");

endmodule

// ===== design/rtc_datapath.sv =====
// ----------------------------------------------------------------------------
// rtc_datapath
// Leaf table, path marks, scan index, cover buffer and result register.
// ----------------------------------------------------------------------------
module rtc_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rtc_pkg::KEY_W-1:0]  in_key_id,
  input  logic [rtc_pkg::TIME_W-1:0] in_time_stamp,
  input  rtc_pkg::cmd_t              cmd,
  output rtc_pkg::sts_t              sts,
  output logic                       out_valid,
  output logic [rtc_pkg::KIND_W-1:0] out_kind,
  output logic [rtc_pkg::NODE_W-1:0] out_node_index,
  output logic                       out_last
);

  logic [rtc_pkg::KEY_W-1:0]  key_mem  [rtc_pkg::LEAVES];
  logic [rtc_pkg::TIME_W-1:0] time_mem [rtc_pkg::LEAVES];
  logic [rtc_pkg::LEAVES-1:0] occ_r;
  logic [rtc_pkg::NODES-1:1]  mark_r;
  logic [rtc_pkg::NODES-1:1]  mark_nxt;

  logic [rtc_pkg::KEY_W-1:0]  key_r;
  logic [rtc_pkg::TIME_W-1:0] time_r;
  logic [rtc_pkg::NODE_W-1:0] idx_r;
  logic [rtc_pkg::NODE_W-1:0] pend_r;
  logic                       pend_v_r;
  logic [rtc_pkg::CNT_W-1:0]  cnt_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [rtc_pkg::KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [rtc_pkg::NODE_W-1:0] out_node_r, out_node_nxt;
  logic                       out_last_r, out_last_nxt;

  logic [rtc_pkg::LEAF_W-1:0] leaf;
  logic [rtc_pkg::NODE_W-1:0] leaf_node;
  logic [rtc_pkg::NODE_W-1:0] node;
  logic [rtc_pkg::NODE_W-1:0] parent;
  logic                       parent_marked;
  logic                       marks_closed;

  assign leaf      = idx_r[rtc_pkg::LEAF_W-1:0];
  assign leaf_node = rtc_pkg::NODE_W'(rtc_pkg::LEAVES) + rtc_pkg::NODE_W'(leaf);
  assign node      = idx_r + rtc_pkg::NODE_W'(1);
  assign parent    = (node == rtc_pkg::NODE_W'(1)) ? node : (node >> 1);
  assign parent_marked = (node == rtc_pkg::NODE_W'(1)) || mark_r[parent];

  always_comb begin
    sts.leaf_free = !occ_r[leaf];
    sts.leaf_hit  = occ_r[leaf] && (key_mem[leaf] == key_r) && (time_mem[leaf] < time_r);
    sts.node_qual = !mark_r[node] && parent_marked &&
                    (cnt_r < rtc_pkg::CNT_W'(rtc_pkg::MAX_RESULTS));
    sts.leaf_end  = (idx_r == rtc_pkg::NODE_W'(rtc_pkg::LEAVES - 1));
    sts.node_end  = (idx_r == rtc_pkg::NODE_W'(rtc_pkg::NODES - 2));
  end

  // Mark the revoked leaf and every ancestor up to the root; drop all on flush
  always_comb begin
    logic [rtc_pkg::NODE_W-1:0] anc;
    mark_nxt = mark_r;
    anc      = leaf_node;
    if (cmd.mark_path) begin
      for (int k = 0; k < rtc_pkg::NODE_W; k++) begin
        if (anc != '0) begin
          mark_nxt[anc] = 1'b1;
        end
        anc = anc >> 1;
      end
    end
    if (cmd.cover_flush) begin
      mark_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_node_nxt  = out_node_r;
    out_last_nxt  = out_last_r;
    if (cmd.write_leaf) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = rtc_pkg::KIND_REGISTERED;
      out_node_nxt  = leaf_node;
      out_last_nxt  = 1'b1;
    end else if (cmd.emit_full) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = rtc_pkg::KIND_FULL;
      out_node_nxt  = '0;
      out_last_nxt  = 1'b1;
    end else if (cmd.cover_take && pend_v_r) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = rtc_pkg::KIND_COVER;
      out_node_nxt  = pend_r;
      out_last_nxt  = 1'b0;
    end else if (cmd.cover_flush) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = pend_v_r ? rtc_pkg::KIND_COVER : rtc_pkg::KIND_EMPTY;
      out_node_nxt  = pend_v_r ? pend_r : '0;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      mark_r      <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mark_r      <= mark_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.load) begin
        idx_r    <= '0;
        pend_v_r <= 1'b0;
        cnt_r    <= '0;
      end else if (cmd.advance) begin
        idx_r <= idx_r + rtc_pkg::NODE_W'(1);
      end
      if (cmd.write_leaf) begin
        occ_r[leaf] <= (key_r != '0);
      end
      if (cmd.cover_take) begin
        pend_v_r <= 1'b1;
        cnt_r    <= cnt_r + rtc_pkg::CNT_W'(1);
      end else if (cmd.cover_flush) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_node_r <= out_node_nxt;
    out_last_r <= out_last_nxt;
    if (cmd.load) begin
      key_r  <= in_key_id;
      time_r <= in_time_stamp;
    end
    if (cmd.cover_take) begin
      pend_r <= node;
    end
    if (cmd.write_leaf) begin
      key_mem[leaf]  <= key_r;
      time_mem[leaf] <= time_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_node_index = out_node_r;
  assign out_last       = out_last_r;

  always_comb begin
    marks_closed = 1'b1;
    for (int j = 2; j < rtc_pkg::NODES; j++) begin
      if (mark_r[j] && !mark_r[j >> 1]) begin
        marks_closed = 1'b0;
      end
    end
  end

  a_marks_closed: assert property (@(posedge clk) disable iff (!rst_n)
    marks_closed)
    else $error("marked node with unmarked parent");

  a_reg_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == rtc_pkg::KIND_REGISTERED) |->
      (out_node_r >= rtc_pkg::NODE_W'(rtc_pkg::LEAVES)))
    else $error("registration reported a non-leaf node");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rtc_pkg::CNT_W'(rtc_pkg::MAX_RESULTS))
    else $error("cover count beyond limit");

  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cover_flush |=> (mark_r == '0) && out_valid_r && out_last_r)
    else $error("flush left marks or gave no final result");

endmodule

// ===== design/revocation_tree_cover_core.sv =====
// ----------------------------------------------------------------------------
// revocation_tree_cover_core
// Complete-subtree revocation over a heap-ordered tree of user leaves.
// ----------------------------------------------------------------------------
//
//  channel  ports                                         transfer when
//  -------  --------------------------------------------  ----------------------
//  input    start, in_mode, in_key_id, in_time_stamp      start high, busy low
//  result   out_valid, out_kind, out_node_index, out_last out_valid high
//
//  One input transfer at a time. Register and revoke walk the leaf table one
//  leaf a cycle; register stops at the first free leaf. Cover walks the
//  nodes one a cycle, from the root to the last leaf. Mode 3 gives no result
//  and leaves the block idle. Results leave from a register, one a cycle,
//  and cannot be held off. Reset empties the table and clears all marks at
//  once; no clearing pass is needed.
//
module revocation_tree_cover_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [rtc_pkg::MODE_W-1:0] in_mode,
  input  logic [rtc_pkg::KEY_W-1:0]  in_key_id,
  input  logic [rtc_pkg::TIME_W-1:0] in_time_stamp,
  output logic                       out_valid,
  output logic [rtc_pkg::KIND_W-1:0] out_kind,
  output logic [rtc_pkg::NODE_W-1:0] out_node_index,
  output logic                       out_last
);

  rtc_pkg::cmd_t cmd;
  rtc_pkg::sts_t sts;

  // Sequencer: dispatch on mode, advance the scan index, issue table updates
  rtc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Datapath: hold the leaf table and marks, buffer one cover node so the
  // final one can carry the last flag
  rtc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_key_id      (in_key_id),
    .in_time_stamp  (in_time_stamp),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_node_index (out_node_index),
    .out_last       (out_last)
  );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for revocation_tree_cover_core. A predictor keeps its
// own copy of the leaf table and path marks and works out the results of each
// command at its transfer. A monitor compares every result strobe against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode 3 has no name in the package; the block ignores it.
  localparam logic [rtc_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_CMDS   = 150;
  localparam int POOL_KEYS     = 8;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int DRAIN_LIMIT   = 2_000;
  localparam int SETTLE_CYCLES = 40;      // a full cover walk plus margin
  localparam logic [rtc_pkg::TIME_W-1:0] STAMP_MAX = '1;

  typedef struct {
    logic [rtc_pkg::MODE_W-1:0] mode;
    logic [rtc_pkg::KEY_W-1:0]  key;
    logic [rtc_pkg::TIME_W-1:0] stamp;
  } tree_cmd_t;

  typedef struct {
    logic [rtc_pkg::KIND_W-1:0] kind;
    logic [rtc_pkg::NODE_W-1:0] node;
    logic                       last;
  } tree_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       start         = 1'b0;
  logic [rtc_pkg::MODE_W-1:0] in_mode       = '0;
  logic [rtc_pkg::KEY_W-1:0]  in_key_id     = '0;
  logic [rtc_pkg::TIME_W-1:0] in_time_stamp = '0;
  logic                       busy;
  logic                       out_valid;
  logic [rtc_pkg::KIND_W-1:0] out_kind;
  logic [rtc_pkg::NODE_W-1:0] out_node_index;
  logic                       out_last;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  revocation_tree_cover_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_key_id     (in_key_id),
    .in_time_stamp (in_time_stamp),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_node_index(out_node_index),
    .out_last      (out_last)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  tree_cmd_t    cmd_backlog[$];    // commands waiting for their transfer
  tree_result_t due_results[$];    // predicted results not yet seen
  logic [rtc_pkg::KEY_W-1:0] known_keys[$]; // non-zero keys handed to registration
  logic [rtc_pkg::KEY_W-1:0] key_pool[POOL_KEYS];

  int errors         = 0;
  int transfers_done = 0;
  int cycle_count    = 0;

  // Predictor copy of the tree. Leaf times of empty leaves are never read.
  logic [rtc_pkg::KEY_W-1:0]  tree_key  [0:rtc_pkg::LEAVES-1];
  logic [rtc_pkg::TIME_W-1:0] tree_stamp[0:rtc_pkg::LEAVES-1];
  bit                         tree_mark [1:rtc_pkg::NODES-1];

  initial begin
    foreach (tree_key[i]) begin
      tree_key[i]   = '0;
      tree_stamp[i] = '0;
    end
    foreach (tree_mark[i]) tree_mark[i] = 1'b0;
  end

  // Append one predicted result to the tail of the expectation queue.
  task automatic expect_result(input logic [rtc_pkg::KIND_W-1:0] kind,
                               input logic [rtc_pkg::NODE_W-1:0] node,
                               input logic                       last);
    tree_result_t r;
    r.kind = kind;
    r.node = node;
    r.last = last;
    due_results.insert(due_results.size(), r);
  endtask

  // --------------------------------------------------------------------------
  // Predictor: apply one accepted command to the tree copy and queue up the
  // results it must produce.
  // --------------------------------------------------------------------------
  task automatic apply_to_tree(input tree_cmd_t c);
    int           n;
    int           count;
    bit           placed;
    placed = 1'b0;
    count  = 0;
    case (c.mode)
      rtc_pkg::MODE_REGISTER: begin
        // Take the lowest empty leaf; a zero key leaves it empty again.
        for (int i = 0; i < rtc_pkg::LEAVES; i++) begin
          if (!placed && tree_key[i] == '0) begin
            tree_key[i]   = c.key;
            tree_stamp[i] = c.stamp;
            expect_result(rtc_pkg::KIND_REGISTERED,
                          rtc_pkg::NODE_W'(rtc_pkg::LEAVES + i), 1'b1);
            placed = 1'b1;
          end
        end
        if (!placed) begin
          expect_result(rtc_pkg::KIND_FULL, '0, 1'b1);
        end
      end
      rtc_pkg::MODE_REVOKE: begin
        // Mark each stale matching leaf and its whole path up to the root.
        for (int i = 0; i < rtc_pkg::LEAVES; i++) begin
          if (tree_key[i] != '0 && tree_key[i] == c.key && tree_stamp[i] < c.stamp) begin
            for (n = rtc_pkg::LEAVES + i; n >= 1; n = n >> 1) tree_mark[n] = 1'b1;
          end
        end
      end
      rtc_pkg::MODE_COVER: begin
        // Marks are closed under ancestors, so index order is level order.
        for (int i = 1; i < rtc_pkg::NODES; i++) begin
          if (!tree_mark[i] && (i == 1 || tree_mark[i >> 1]) &&
              count < rtc_pkg::MAX_RESULTS) begin
            expect_result(rtc_pkg::KIND_COVER, rtc_pkg::NODE_W'(i), 1'b0);
            count++;
          end
        end
        if (count == 0) begin
          expect_result(rtc_pkg::KIND_EMPTY, '0, 1'b1);
        end else begin
          due_results[due_results.size() - 1].last = 1'b1;
        end
        foreach (tree_mark[i]) tree_mark[i] = 1'b0;
      end
      default: ;  // unused mode: no result, no change
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_cmd(input logic [rtc_pkg::MODE_W-1:0] mode,
                           input logic [rtc_pkg::KEY_W-1:0]  key,
                           input logic [rtc_pkg::TIME_W-1:0] stamp);
    tree_cmd_t c;
    c.mode  = mode;
    c.key   = key;
    c.stamp = stamp;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endtask

  function automatic logic [rtc_pkg::KEY_W-1:0] fresh_key();
    logic [rtc_pkg::KEY_W-1:0] k;
    k = {$urandom(), $urandom()};
    if (k == '0) k = 64'd1;
    return k;
  endfunction

  function automatic logic [rtc_pkg::KEY_W-1:0] known_key();
    return known_keys[$urandom_range(known_keys.size() - 1, 0)];
  endfunction

  // --------------------------------------------------------------------------
  // Driver: hold a command until its transfer, then advance to the next one
  // or idle. Each edge makes at most one assignment to start.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    tree_cmd_t cur;
    tree_cmd_t nxt;
    bit        idle_now;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        cur.mode  = in_mode;
        cur.key   = in_key_id;
        cur.stamp = in_time_stamp;
        apply_to_tree(cur);
        transfers_done++;
      end
      if (!start || !busy) begin
        // Keep a quiet window with no idling in the middle of the run.
        idle_now = ($urandom_range(99, 0) < 6) &&
                   !(transfers_done >= 90 && transfers_done < 160);
        if (cmd_backlog.size() != 0 && !idle_now) begin
          nxt = cmd_backlog.pop_front();
          start         <= 1'b1;
          in_mode       <= nxt.mode;
          in_key_id     <= nxt.key;
          in_time_stamp <= nxt.stamp;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: results cannot be held off, so take one at every strobe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_proc
    tree_result_t want;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind=%0d node=%0d last=%0d",
                 $time, out_kind, out_node_index, out_last);
      end else begin
        want = due_results.pop_front();
        if (out_kind !== want.kind) begin
          errors++;
          $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, out_kind);
        end
        if (out_node_index !== want.node) begin
          errors++;
          $display("%0t: node_index mismatch, expected %0d, got %0d",
                   $time, want.node, out_node_index);
        end
        if (out_last !== want.last) begin
          errors++;
          $display("%0t: last mismatch, expected %0d, got %0d", $time, want.last, out_last);
        end
      end
    end
  end

  // Watchdog: give up well beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: build the command list, release reset, drain, report.
  // --------------------------------------------------------------------------
  initial begin : main_proc
    int                         random_cmds;
    int                         roll;
    int                         drain;
    logic [rtc_pkg::KEY_W-1:0]  k;
    logic [rtc_pkg::TIME_W-1:0] t;

    foreach (key_pool[i]) begin
      key_pool[i] = fresh_key();
      known_keys.insert(known_keys.size(), key_pool[i]);
    end
    known_keys.insert(known_keys.size(), '1);

    // Directed opening.
    queue_cmd(rtc_pkg::MODE_COVER, '0, '0);            // untouched tree: root only
    queue_cmd(MODE_UNUSED, '1, STAMP_MAX);             // ignored entirely
    queue_cmd(rtc_pkg::MODE_REVOKE, '0, STAMP_MAX);    // empty table never matches
    queue_cmd(rtc_pkg::MODE_REGISTER, '0, STAMP_MAX);  // zero key: leaf stays empty
    queue_cmd(rtc_pkg::MODE_REGISTER, '1, '0);         // lands in the same leaf
    queue_cmd(rtc_pkg::MODE_REVOKE, '1, '0);           // equal time: no mark
    queue_cmd(rtc_pkg::MODE_REVOKE, '1, 32'd1);        // older than epoch: mark
    queue_cmd(rtc_pkg::MODE_COVER, '0, '0);            // siblings along one path
    queue_cmd(rtc_pkg::MODE_COVER, '0, '0);            // marks cleared: root again
    queue_cmd(rtc_pkg::MODE_REGISTER, key_pool[0], 32'd50);
    queue_cmd(rtc_pkg::MODE_REGISTER, key_pool[1], 32'd60);
    queue_cmd(rtc_pkg::MODE_REVOKE, key_pool[0], 32'd50);  // equal time: no mark
    queue_cmd(rtc_pkg::MODE_REVOKE, key_pool[1], 32'd61);
    queue_cmd(rtc_pkg::MODE_REVOKE, '1, STAMP_MAX);    // marks accumulate
    queue_cmd(rtc_pkg::MODE_COVER, '0, '0);

    // Random body: revoke runs closed by covers, sparse registrations so the
    // table fills late, and a little noise in the unused mode.
    random_cmds = 0;
    while (random_cmds < RANDOM_CMDS) begin
      roll = $urandom_range(99, 0);
      if (roll < 10) begin
        roll = $urandom_range(99, 0);
        if (roll < 15) begin
          k = '0;
        end else if (roll < 40) begin
          k = fresh_key();
          known_keys.insert(known_keys.size(), k);
        end else begin
          k = key_pool[$urandom_range(POOL_KEYS - 1, 0)];
        end
        // Keep registration times below the maximum so any leaf can be revoked.
        t = ($urandom_range(99, 0) < 70) ? $urandom_range(100, 0)
                                         : $urandom_range(32'hFFFF_FFFE, 0);
        queue_cmd(rtc_pkg::MODE_REGISTER, k, t);
        random_cmds++;
      end else if (roll < 14) begin
        queue_cmd(MODE_UNUSED, {$urandom(), $urandom()}, $urandom());
      end else if (roll < 70) begin
        roll = $urandom_range(99, 0);
        k = (roll < 10) ? '0 : (roll < 25) ? fresh_key() : known_key();
        roll = $urandom_range(99, 0);
        t = (roll < 50) ? $urandom_range(120, 0) : (roll < 75) ? $urandom() : STAMP_MAX;
        queue_cmd(rtc_pkg::MODE_REVOKE, k, t);
        random_cmds++;
      end else begin
        queue_cmd(rtc_pkg::MODE_COVER, {$urandom(), $urandom()}, $urandom());
        random_cmds++;
      end
    end

    // Closing: fill the table past full, revoke every key, expect no cover.
    for (int i = 0; i <= rtc_pkg::LEAVES; i++)
      queue_cmd(rtc_pkg::MODE_REGISTER, known_key(), $urandom_range(1000, 0));
    foreach (known_keys[i]) queue_cmd(rtc_pkg::MODE_REVOKE, known_keys[i], STAMP_MAX);
    queue_cmd(rtc_pkg::MODE_COVER, '0, '0);
    queue_cmd(rtc_pkg::MODE_COVER, '0, '0);

    // Hold reset, then let the driver go.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || start) @(posedge clk);
    drain = 0;
    while ((due_results.size() != 0 || busy) && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (due_results.size() != 0) begin
      errors += due_results.size();
      $display("%0t: %0d predicted results never arrived, expected kind=%0d node=%0d, got none",
               $time, due_results.size(), due_results[0].kind, due_results[0].node);
    end
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
